@@ hw/rtl/assert_macros.svh @@
// assertion macros for the deframer rtl
// no dependencies; included by the deframer top level, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks held off during reset
`define DFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks held off during reset
`define DFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dfd_pkg.sv @@
// types, constants and helpers for the detector frame deframer
// no dependencies; imported by every deframer module
`timescale 1ns / 1ps

package dfd_pkg;

    localparam int CHANNELS_PER_CHIP = 68;
    localparam int BUCKET_LIMIT      = 512;
    localparam int HEADER_BYTES      = 256;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PW           = $clog2(FIFO_DEPTH);

    // frame type codes from header bytes 5..6
    localparam logic [15:0] FTYPE_PARTIAL = 16'd1;
    localparam logic [15:0] FTYPE_FULL    = 16'd2;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [8:0]   row_index;
        logic [8:0]   time_bucket;
        logic [11:0]  sample_value;
        logic [31:0]  event_index;
        logic [47:0]  event_time;
        logic [31:0]  window_multiplicity;
        logic [31:0]  frame_bytes;
        logic         last;
    } t_result;

    // up to two results per accepted byte, res0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic in_data;
        logic walk_done;
        logic full_type;
    } t_dec_stat;

    // chip * channels per chip + channel, kept to the 9-bit row field
    function automatic logic [8:0] f_row(input logic [1:0] chip, input logic [7:0] ch);
        logic [9:0] s;
        s = 10'(chip) * 10'(CHANNELS_PER_CHIP) + 10'(ch);
        return s[8:0];
    endfunction

endpackage

@@ hw/rtl/dfd_in_if.sv @@
// byte stream channel into the deframer
// depends on nothing but the handshake convention valid/ready
`timescale 1ns / 1ps

interface dfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

@@ hw/rtl/dfd_out_if.sv @@
// result channel out of the deframer
// depends on nothing but the handshake convention valid/ready
`timescale 1ns / 1ps

interface dfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [8:0]  row_index;
    logic [8:0]  time_bucket;
    logic [11:0] sample_value;
    logic [31:0] event_index;
    logic [47:0] event_time;
    logic [31:0] window_multiplicity;
    logic [31:0] frame_bytes;
    logic        last;

    modport source (output valid, output kind, output row_index, output time_bucket,
                    output sample_value, output event_index, output event_time,
                    output window_multiplicity, output frame_bytes, output last,
                    input ready);
    modport sink   (input valid, input kind, input row_index, input time_bucket,
                    input sample_value, input event_index, input event_time,
                    input window_multiplicity, input frame_bytes, input last,
                    output ready);
endinterface

@@ hw/rtl/dfd_decode.sv @@
// frame state and per-byte decode: header capture, sample unpacking, frame end
// depends on dfd_pkg
`timescale 1ns / 1ps

module dfd_decode
    import dfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_push      o_push,
    output t_dec_stat  o_stat
);

    localparam logic [31:0] HDR_LAST = 32'(HEADER_BYTES - 1);

    logic [31:0] r_pos,   n_pos;
    logic        r_in_data, n_in_data;
    logic [23:0] r_fs,    n_fs;
    logic [15:0] r_ftype, n_ftype;
    logic [15:0] r_hs,    n_hs;
    logic [47:0] r_time,  n_time;
    logic [31:0] r_index, n_index;
    logic [31:0] r_mult,  n_mult;
    logic [31:0] r_count, n_count;
    logic [31:0] r_wa,    n_wa;
    logic [6:0]  r_ch,    n_ch;
    logic [9:0]  r_bkt,   n_bkt;
    logic [2:0]  r_pc,    n_pc;
    logic [1:0]  r_pchip, n_pchip;
    logic        r_done,  n_done;

    logic [31:0] pos_inc;
    logic [23:0] size_diff;
    logic [7:0]  ch_sum;
    logic [15:0] half;
    logic        have_sample;
    logic        have_end;
    t_result     smp, hdr, eof;
    t_push       push;

    assign pos_inc = r_pos + 32'd1;

    always_comb begin
        n_pos = r_pos;  n_in_data = r_in_data;  n_fs = r_fs;  n_ftype = r_ftype;
        n_hs = r_hs;  n_time = r_time;  n_index = r_index;  n_mult = r_mult;
        n_count = r_count;  n_wa = r_wa;  n_ch = r_ch;  n_bkt = r_bkt;
        n_pc = r_pc;  n_pchip = r_pchip;  n_done = r_done;
        smp = '0;  hdr = '0;  eof = '0;  push = '0;
        have_sample = 1'b0;  have_end = 1'b0;
        size_diff = '0;  ch_sum = '0;
        half = n_wa[15:0];

        if (i_accept && !r_in_data) begin
            // header fields, big-endian shift-in
            if (r_pos >= 32'd1  && r_pos <= 32'd3)  n_fs    = {r_fs[15:0], i_byte};
            if (r_pos >= 32'd5  && r_pos <= 32'd6)  n_ftype = {r_ftype[7:0], i_byte};
            if (r_pos >= 32'd8  && r_pos <= 32'd9)  n_hs    = {r_hs[7:0], i_byte};
            if (r_pos >= 32'd16 && r_pos <= 32'd21) n_time  = {r_time[39:0], i_byte};
            if (r_pos >= 32'd22 && r_pos <= 32'd25) n_index = {r_index[23:0], i_byte};
            if (r_pos >= 32'd75 && r_pos <= 32'd78) n_mult  = {r_mult[23:0], i_byte};
            if (r_pos < HDR_LAST) begin
                n_pos = pos_inc;
            end else begin
                hdr.kind                = KIND_HEADER;
                hdr.event_index         = n_index;
                hdr.event_time          = n_time;
                hdr.window_multiplicity = n_mult;
                n_pos = '0;  n_wa = '0;  n_ch = '0;  n_bkt = '0;
                n_pc = '0;  n_pchip = '0;  n_done = 1'b0;
                size_diff = n_fs - {8'h00, n_hs};
                if (n_fs > {8'h00, n_hs}) begin
                    n_count   = {size_diff, 8'h00};
                    n_in_data = 1'b1;
                end else begin
                    n_count  = '0;
                    have_end = 1'b1;
                end
            end
        end else if (i_accept) begin
            n_wa = {r_wa[23:0], i_byte};
            half = n_wa[15:0];
            if (r_ftype == FTYPE_PARTIAL && r_pos[1:0] == 2'b11) begin
                have_sample      = 1'b1;
                smp.row_index    = f_row(n_wa[31:30], {1'b0, n_wa[29:23]});
                smp.time_bucket  = n_wa[22:14];
                smp.sample_value = n_wa[11:0];
            end else if (r_ftype == FTYPE_FULL && r_pos[0] && !r_done) begin
                have_sample      = 1'b1;
                smp.time_bucket  = r_bkt[8:0];
                smp.sample_value = half[11:0];
                if (!r_pc[0]) begin
                    n_pchip       = half[15:14];
                    smp.row_index = f_row(half[15:14], {1'b0, r_ch});
                end else begin
                    smp.row_index = f_row(r_pchip, {1'b0, r_ch} + 8'd1);
                end
                n_pc = r_pc + 3'd1;
                // group of eight halfwords done: step the channel/bucket walk
                if (r_pc == 3'd7) begin
                    ch_sum = {1'b0, r_ch} + 8'd2;
                    if (ch_sum >= 8'(CHANNELS_PER_CHIP)) begin
                        n_ch  = '0;
                        n_bkt = r_bkt + 10'd1;
                    end else begin
                        n_ch = ch_sum[6:0];
                    end
                    if (n_bkt >= 10'(BUCKET_LIMIT)) n_done = 1'b1;
                end
            end
            if (pos_inc >= r_count) begin
                have_end  = 1'b1;
                n_pos     = '0;
                n_in_data = 1'b0;
            end else begin
                n_pos = pos_inc;
            end
        end

        eof.kind        = KIND_END;
        eof.frame_bytes = {n_fs, 8'h00};

        // order: header or sample first, frame end after it
        if (hdr.kind == KIND_HEADER) begin
            push.res0 = hdr;
            push.res1 = eof;
            push.cnt  = have_end ? 2'd2 : 2'd1;
        end else if (have_sample) begin
            push.res0 = smp;
            push.res1 = eof;
            push.cnt  = have_end ? 2'd2 : 2'd1;
        end else if (have_end) begin
            push.res0 = eof;
            push.cnt  = 2'd1;
        end
        push.res0.last = (push.cnt == 2'd1);
        push.res1.last = (push.cnt == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;  r_in_data <= 1'b0;  r_fs <= '0;  r_ftype <= '0;
            r_hs <= '0;  r_time <= '0;  r_index <= '0;  r_mult <= '0;
            r_count <= '0;  r_wa <= '0;  r_ch <= '0;  r_bkt <= '0;
            r_pc <= '0;  r_pchip <= '0;  r_done <= 1'b0;
        end else begin
            r_pos <= n_pos;  r_in_data <= n_in_data;  r_fs <= n_fs;  r_ftype <= n_ftype;
            r_hs <= n_hs;  r_time <= n_time;  r_index <= n_index;  r_mult <= n_mult;
            r_count <= n_count;  r_wa <= n_wa;  r_ch <= n_ch;  r_bkt <= n_bkt;
            r_pc <= n_pc;  r_pchip <= n_pchip;  r_done <= n_done;
        end
    end

    assign o_push           = push;
    assign o_stat.in_data   = r_in_data;
    assign o_stat.walk_done = r_done;
    assign o_stat.full_type = (r_ftype == FTYPE_FULL);

endmodule

@@ hw/rtl/dfd_result_fifo.sv @@
// small result queue: takes up to two results a cycle, gives one beat a cycle while popped
// depends on dfd_pkg
`timescale 1ns / 1ps

module dfd_result_fifo
    import dfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_push              i_push,
    input  logic               i_pop,
    output logic               o_valid,
    output t_result            o_head,
    output logic [FIFO_PW:0]   o_count
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   r_wp, n_wp;
    logic [FIFO_PW-1:0]   r_rp, n_rp;
    logic [FIFO_PW:0]     r_count, n_count;
    logic                 pop;

    assign pop = i_pop && (r_count != '0);

    always_comb begin
        n_wp    = r_wp + FIFO_PW'(i_push.cnt);
        n_rp    = pop ? r_rp + FIFO_PW'(1) : r_rp;
        n_count = r_count + (FIFO_PW + 1)'(i_push.cnt) - (FIFO_PW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wp] <= i_push.res0;
        if (i_push.cnt == 2'd2) r_mem[r_wp + FIFO_PW'(1)] <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

@@ hw/rtl/detector_frame_deframer.sv @@
// detector frame deframer, top level
// depends on dfd_pkg, dfd_in_if, dfd_out_if, dfd_decode, dfd_result_fifo, assert_macros.svh
`timescale 1ns / 1ps

// The deframer takes a readout stream one byte per beat on i_in and gives
// result beats on o_out. Each frame opens with a 256-byte big-endian header;
// after its last byte one header beat (kind 1) carries event time, event
// index and integrated multiplicity. The (frame size - header size) * 256
// data bytes that follow are unpacked: type 1 frames as 32-bit words, one
// sample beat (kind 0) per word; type 2 frames as 16-bit halfwords walking
// channels and buckets, silent from bucket 512 on; other types give no
// samples. After the last data byte an end-of-frame beat (kind 2) carries the
// frame byte count. A header whose size is not below the frame size gives
// the header beat and the end beat on the same byte. last marks the final
// beat caused by a byte. Rate: one byte per clock cycle while i_in.ready is
// high. The decode is single pass from the frame state registers into a
// four-entry result queue, which registers the results. The output side moves
// one beat per cycle while o_out.ready is high, and i_in.ready drops only
// while fewer than two queue entries are free.

`include "assert_macros.svh"

module detector_frame_deframer
    import dfd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    dfd_in_if.sink         i_in,
    dfd_out_if.source      o_out
);

    t_push               w_push;
    t_dec_stat           w_stat;
    t_result             w_head;
    logic [FIFO_PW:0]    w_count;
    logic                w_accept;
    logic                w_eof_push;
    logic                w_hdr_only;

    // room for the worst case of two beats from one byte
    assign i_in.ready = (w_count <= (FIFO_PW + 1)'(FIFO_DEPTH - 2));
    assign w_accept   = i_in.valid && i_in.ready;

    // per-byte decode and frame state
    dfd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.stream_byte),
        .o_push   (w_push),
        .o_stat   (w_stat)
    );

    // result queue between decode and the output port
    dfd_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (o_out.ready),
        .o_valid  (o_out.valid),
        .o_head   (w_head),
        .o_count  (w_count)
    );

    assign o_out.kind                = w_head.kind;
    assign o_out.row_index           = w_head.row_index;
    assign o_out.time_bucket         = w_head.time_bucket;
    assign o_out.sample_value        = w_head.sample_value;
    assign o_out.event_index         = w_head.event_index;
    assign o_out.event_time          = w_head.event_time;
    assign o_out.window_multiplicity = w_head.window_multiplicity;
    assign o_out.frame_bytes         = w_head.frame_bytes;
    assign o_out.last                = w_head.last;

    // frame end in this push, either alone or behind a header or sample
    assign w_eof_push = (w_push.cnt == 2'd2) ||
                        (w_push.cnt == 2'd1 && w_push.res0.kind == KIND_END);
    // header with data to follow
    assign w_hdr_only = (w_push.cnt == 2'd1) && (w_push.res0.kind == KIND_HEADER);

    // a pair of beats from one byte: only the second carries last
    `DFD_ASSERT_IMP(a_pair_last, i_clk, i_rst_n, w_push.cnt == 2'd2, w_push.res1.last && !w_push.res0.last && w_push.res1.kind == KIND_END, "two-beat push with wrong last or kind")
    // frame end always drops back to the header phase
    `DFD_ASSERT_NXT(a_eof_header, i_clk, i_rst_n, w_eof_push, !w_stat.in_data, "data phase kept after frame end")
    // a header with a non-empty data part enters the data phase
    `DFD_ASSERT_NXT(a_hdr_data, i_clk, i_rst_n, w_hdr_only, w_stat.in_data, "data phase not entered after header")
    // full readout gives no sample once the bucket walk is finished
    `DFD_ASSERT_IMP(a_walk_stop, i_clk, i_rst_n, w_push.cnt != 2'd0 && w_push.res0.kind == KIND_SAMPLE && w_stat.full_type, !w_stat.walk_done, "sample after bucket limit")

endmodule
